@@ hw/rtl/gtmd_pkg.sv @@
package gtmd_pkg;

    localparam int RATE_W    = 16;
    localparam int GAIN_W    = 32;
    localparam int MULT_W    = 24;
    localparam int DELTA_W   = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_X = 2'd0,
        REG_GAIN_Y = 2'd1,
        REG_MULT   = 2'd2
    } cfg_reg_t;

    localparam logic signed [GAIN_W-1:0]  GAIN_RESET = 32'sd65536;
    localparam logic        [MULT_W-1:0]  MULT_RESET = 24'd65536;
    localparam logic signed [DELTA_W-1:0] DELTA_MAX  = 16'sh7fff;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN  = 16'sh8000;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic                     emit;
    } sample_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } delta_t;

    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] delta;
    } lane_res_t;

endpackage

@@ hw/rtl/gyro_to_mouse_delta.sv @@
// gyro rate to pointer delta, with soft deadzone and sub-pixel carry
// sample channel: sample_valid / sample_ready, one item holds rate_x, rate_y
//   and emit; the item is taken when both are high
// delta channel: delta_valid / delta_ready, one item per sample with emit set;
//   samples without emit only move the kept residuals
// config: cfg_we writes cfg_data into gain_x, gain_y or multiplier picked by
//   cfg_index, in the same cycle; other indexes are dropped
// path: a taken sample goes through the MAG, PART, SUM and CAP states, then
//   the divide loop when the soft curve applies (magnitude below one), then
//   ACC and HOLD; the merge then registers the delta item
// pacing: a new sample is taken only once both lanes are idle again; x and y
//   run side by side and the curve's bit-per-cycle divide loop sets the pace
// stall: a finished delta waits in the output register; the next sample is
//   still taken and worked, and the lanes hold their result until the
//   output register frees up
// reset: gains and multiplier go to 1.0, residuals to zero, no item pending
module gyro_to_mouse_delta
    import gtmd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sample_t              sample,
    output logic                 delta_valid,
    input  logic                 delta_ready,
    output delta_t               delta,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic signed [GAIN_W-1:0] gain_x_reg, gain_x_next;
    logic signed [GAIN_W-1:0] gain_y_reg, gain_y_next;
    logic [MULT_W-1:0]        mult_reg, mult_next;

    logic      accept;
    logic      take;
    logic      idle_x, idle_y;
    lane_res_t res_x, res_y;

    always_comb
    begin
        gain_x_next = gain_x_reg;
        gain_y_next = gain_y_reg;
        mult_next   = mult_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_X: gain_x_next = $signed(cfg_data);
                REG_GAIN_Y: gain_y_next = $signed(cfg_data);
                REG_MULT:   mult_next   = cfg_data[MULT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x_reg <= GAIN_RESET;
            gain_y_reg <= GAIN_RESET;
            mult_reg   <= MULT_RESET;
        end
        else
        begin
            gain_x_reg <= gain_x_next;
            gain_y_reg <= gain_y_next;
            mult_reg   <= mult_next;
        end
    end

    assign sample_ready = idle_x && idle_y;
    assign accept       = sample_valid && sample_ready;

    gtmd_lane #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .rate       (sample.rate_x),
        .gain       (gain_x_reg),
        .multiplier (mult_reg),
        .take       (take),
        .res        (res_x),
        .idle       (idle_x)
    );

    gtmd_lane #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lane_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .rate       (sample.rate_y),
        .gain       (gain_y_reg),
        .multiplier (mult_reg),
        .take       (take),
        .res        (res_y),
        .idle       (idle_y)
    );

    gtmd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .emit        (sample.emit),
        .res_x       (res_x),
        .res_y       (res_y),
        .take        (take),
        .delta_valid (delta_valid),
        .delta_ready (delta_ready),
        .delta       (delta)
    );

endmodule

@@ hw/rtl/gtmd_lane.sv @@
module gtmd_lane
    import gtmd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [RATE_W-1:0] rate,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic        [MULT_W-1:0] multiplier,
    input  logic                     take,
    output lane_res_t                res,
    output logic                     idle
);

    localparam int FB     = FRACTION_BITS;
    localparam int PROD_W = RATE_W + GAIN_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int SPLIT  = 24;
    localparam int HI_W   = MAG_W - SPLIT;
    localparam int PL_W   = SPLIT + MULT_W;
    localparam int PH_W   = HI_W + MULT_W;
    localparam int FULL_W = MAG_W + MULT_W;
    localparam int SHR_W  = FULL_W - FB;
    localparam int V_W    = FB + 18;
    localparam int DEN_W  = FB + 2;
    localparam int REM_W  = FB + 2;
    localparam int CNT_W  = $clog2(FB + 1);
    localparam int S_W    = V_W + 2;
    localparam int IP_W   = S_W - FB;
    localparam int RES_W  = FB + 1;

    localparam logic [SHR_W-1:0] CAP     = SHR_W'(1) << (FB + 17);
    localparam logic [V_W-1:0]   ONE_V   = V_W'(1) << FB;
    localparam logic [DEN_W-1:0] TWO_D   = DEN_W'(1) << (FB + 1);
    localparam logic [IP_W-1:0]  POS_LIM = IP_W'(32767);
    localparam logic [IP_W-1:0]  NEG_LIM = IP_W'(32768);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(FB - 1);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MAG  = 9'b000000010,
        ST_PART = 9'b000000100,
        ST_SUM  = 9'b000001000,
        ST_CAP  = 9'b000010000,
        ST_DIV  = 9'b000100000,
        ST_ACC  = 9'b001000000,
        ST_HOLD = 9'b010000000,
        ST_SPARE = 9'b100000000
    } lane_state_t;

    lane_state_t              state_reg, state_next;
    logic signed [RES_W-1:0]  residual_reg, residual_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [PROD_W-1:0] p_reg, p_next;
    logic                     neg_reg, neg_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [PL_W-1:0]          pp_lo_reg, pp_lo_next;
    logic [PH_W-1:0]          pp_hi_reg, pp_hi_next;
    logic [FULL_W-1:0]        full_reg, full_next;
    logic [V_W-1:0]           v_reg, v_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [FB-1:0]            q_reg, q_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;

    logic [SHR_W-1:0]         shr;
    logic [V_W-1:0]           capped;
    logic                     bend;
    logic [REM_W:0]           trial;
    logic                     ge;
    logic [REM_W-1:0]         rem_step;
    logic [FB-1:0]            q_step;
    logic signed [S_W-1:0]    v_ext;
    logic signed [S_W-1:0]    sum;
    logic [S_W-1:0]           mag_sum;
    logic [IP_W-1:0]          ip;
    logic signed [RES_W-1:0]  frac_s;
    logic signed [DELTA_W-1:0] delta_sat;

    // capped magnitude and curve check
    assign shr    = full_reg[FULL_W-1:FB];
    assign capped = (shr > CAP) ? V_W'(CAP) : V_W'(shr);
    assign bend   = (capped != '0) && (capped < ONE_V);

    // one restoring divide step
    assign trial    = {rem_reg, 1'b0};
    assign ge       = trial >= (REM_W + 1)'(den_reg);
    assign rem_step = ge ? REM_W'(trial - (REM_W + 1)'(den_reg)) : REM_W'(trial);
    assign q_step   = {q_reg[FB-2:0], ge};

    // residual add and split
    assign v_ext   = $signed(S_W'(v_reg));
    assign sum     = (neg_reg ? -v_ext : v_ext) + S_W'(residual_reg);
    assign mag_sum = sum[S_W-1] ? S_W'(-sum) : S_W'(sum);
    assign ip      = mag_sum[S_W-1:FB];
    assign frac_s  = $signed({1'b0, mag_sum[FB-1:0]});

    always_comb
    begin
        if (!sum[S_W-1])
        begin
            delta_sat = (ip > POS_LIM) ? DELTA_MAX : $signed(DELTA_W'(ip));
        end
        else
        begin
            delta_sat = (ip > NEG_LIM) ? DELTA_MIN : $signed(DELTA_W'(IP_W'(0) - ip));
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        residual_next = residual_reg;
        cnt_next      = cnt_reg;
        p_next        = p_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        pp_lo_next    = pp_lo_reg;
        pp_hi_next    = pp_hi_reg;
        full_next     = full_reg;
        v_next        = v_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        q_next        = q_reg;
        delta_next    = delta_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    p_next     = PROD_W'(rate) * PROD_W'(gain);
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                neg_next   = p_reg[PROD_W-1];
                mag_next   = p_reg[PROD_W-1] ? MAG_W'(-p_reg) : MAG_W'(p_reg);
                state_next = ST_PART;
            end
            ST_PART:
            begin
                pp_lo_next = PL_W'(mag_reg[SPLIT-1:0]) * PL_W'(multiplier);
                pp_hi_next = PH_W'(mag_reg[MAG_W-1:SPLIT]) * PH_W'(multiplier);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                full_next  = FULL_W'(pp_lo_reg) + (FULL_W'(pp_hi_reg) << SPLIT);
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                v_next = capped;
                if (bend)
                begin
                    rem_next   = REM_W'(capped);
                    den_next   = TWO_D - DEN_W'(capped);
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                q_next   = q_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_END)
                begin
                    v_next     = V_W'(q_step);
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                residual_next = sum[S_W-1] ? -frac_s : frac_s;
                delta_next    = delta_sat;
                state_next    = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            residual_reg <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            residual_reg <= residual_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        pp_lo_reg <= pp_lo_next;
        pp_hi_reg <= pp_hi_next;
        full_reg  <= full_next;
        v_reg     <= v_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        delta_reg <= delta_next;
    end

    assign res.valid = (state_reg == ST_HOLD);
    assign res.delta = delta_reg;
    assign idle      = (state_reg == ST_IDLE);

endmodule

@@ hw/rtl/gtmd_merge.sv @@
module gtmd_merge
    import gtmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      emit,
    input  lane_res_t res_x,
    input  lane_res_t res_y,
    output logic      take,
    output logic      delta_valid,
    input  logic      delta_ready,
    output delta_t    delta
);

    logic   emit_reg, emit_next;
    logic   valid_reg, valid_next;
    delta_t data_reg, data_next;

    assign take = res_x.valid && res_y.valid && (!valid_reg || delta_ready);

    always_comb
    begin
        emit_next  = accept ? emit : emit_reg;
        valid_next = valid_reg && !delta_ready;
        data_next  = data_reg;
        if (take)
        begin
            valid_next = emit_reg;
            if (emit_reg)
            begin
                data_next.delta_x = res_x.delta;
                data_next.delta_y = res_y.delta;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_reg <= emit_next;
        data_reg <= data_next;
    end

    assign delta_valid = valid_reg;
    assign delta       = data_reg;

endmodule

@@ hw/rtl/gtmd_checker.sv @@
module gtmd_checker
    import gtmd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_ready,
    input logic    delta_valid,
    input logic    delta_ready,
    input delta_t  delta
);

    // a taken sample keeps the lanes busy
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready
    ) else $error("sample_ready high right after an item was taken");

    // no delta item can come straight out of an idle block
    a_no_instant_delta: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !$rose(delta_valid)
    ) else $error("delta item appeared one cycle after a sample");

    // stalled delta item holds
    a_delta_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (delta_valid && !delta_ready) |=> (delta_valid && $stable(delta))
    ) else $error("stalled delta item dropped or changed");

endmodule

bind gyro_to_mouse_delta gtmd_checker u_gtmd_checker (.*);

@@ sim/tb_gyro_to_mouse_delta.sv @@
`timescale 1ns / 100ps

module tb_gyro_to_mouse_delta;

    import gtmd_pkg::*;

    typedef longint unsigned u64_t;
    typedef longint          s64_t;

    localparam int   FRAC          = 16;
    localparam int   ITEMS_PER_RUN = 125;
    localparam int   NUM_RUNS      = 6;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   SETTLE_CYCLES = FRAC + 12;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   NUM_DIRECTED  = 27;

    localparam u64_t ONE_Q     = u64_t'(1) << FRAC;
    localparam u64_t FRAC_MASK = ONE_Q - 1;
    localparam u64_t MAG_CAP   = u64_t'(1) << (FRAC + 17);

    localparam logic [CFG_IDX_W-1:0]    REG_SPARE = 2'd3;
    localparam logic signed [RATE_W-1:0] RATE_MAX = 16'sh7fff;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 16'sh8000;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_W-1:0]      data;
        sample_t               item;
        logic                  typed;
        delta_t                want;
    } step_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_ready;
    sample_t              sample;
    logic                 delta_valid;
    logic                 delta_ready;
    delta_t               delta;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic signed [GAIN_W-1:0] gain_x_cfg = GAIN_RESET;
    logic signed [GAIN_W-1:0] gain_y_cfg = GAIN_RESET;
    logic [MULT_W-1:0]        mult_cfg   = MULT_RESET;
    s64_t                     carry_x    = 0;
    s64_t                     carry_y    = 0;

    delta_t pending_deltas[$];
    delta_t oldest_delta;
    int     mismatches   = 0;
    int     cycles       = 0;
    int     gap_pct      = 0;
    int     stall_pct    = 0;
    bit     hold_off_req = 1'b0;

    step_row_t directed [NUM_DIRECTED] = '{
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MAX, RATE_MIN, 1'b1}, 1'b1,
          '{DELTA_MAX, DELTA_MIN}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd0, 16'sd0, 1'b1}, 1'b1,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd1, -16'sd1, 1'b1}, 1'b1,
          '{16'sd1, -16'sd1}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd12345, -16'sd2222, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{-16'sd1, RATE_MAX, 1'b1}, 1'b1,
          '{-16'sd1, DELTA_MAX}},
        '{ROW_WRITE, REG_GAIN_X, 32'h7fffffff, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_GAIN_Y, 32'h80000000, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_MULT, 32'hffffffff, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_SPARE, 32'h00000000, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MAX, RATE_MAX, 1'b1}, 1'b1,
          '{DELTA_MAX, DELTA_MIN}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MIN, RATE_MIN, 1'b1}, 1'b1,
          '{DELTA_MIN, DELTA_MAX}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd1, 16'sd1, 1'b1}, 1'b1,
          '{DELTA_MAX, DELTA_MIN}},
        '{ROW_WRITE, REG_MULT, 32'h00000000, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MAX, RATE_MIN, 1'b1}, 1'b1,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_GAIN_X, 32'h00000001, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_GAIN_Y, 32'hfffffffd, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_MULT, 32'h00010000, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MAX, RATE_MAX, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MIN, 16'sd100, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd5, -16'sd5, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd21845, -16'sd21845, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd0, 16'sd1, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{RATE_MIN, RATE_MIN, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_GAIN_X, 32'h00010000, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_WRITE, REG_GAIN_Y, 32'h00000002, '{16'sd0, 16'sd0, 1'b0}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{16'sd1, RATE_MAX, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_GAIN_X, 32'd0, '{-16'sd1, RATE_MIN, 1'b1}, 1'b0,
          '{16'sd0, 16'sd0}}
    };

    gyro_to_mouse_delta #(
        .FRACTION_BITS(FRAC)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .delta_valid  (delta_valid),
        .delta_ready  (delta_ready),
        .delta        (delta),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // scale, soft deadzone, residual carry and split for one axis
    function automatic logic signed [DELTA_W-1:0] scale_axis(
        input logic signed [RATE_W-1:0] rate,
        input logic signed [GAIN_W-1:0] gain,
        inout s64_t                     carry
    );
        s64_t prod;
        s64_t total;
        s64_t whole;
        u64_t mag;
        u64_t v;
        bit   neg;
        prod = s64_t'(rate) * s64_t'(gain);
        neg  = prod < 0;
        mag  = neg ? u64_t'(-prod) : u64_t'(prod);
        v    = (mag >> FRAC) * u64_t'(mult_cfg)
             + (((mag & FRAC_MASK) * u64_t'(mult_cfg)) >> FRAC);
        if (v > MAG_CAP)
        begin
            v = MAG_CAP;
        end
        if (v != 0 && v < ONE_Q)
        begin
            v = (v << FRAC) / ((ONE_Q << 1) - v);
        end
        total = (neg ? -s64_t'(v) : s64_t'(v)) + carry;
        if (total < 0)
        begin
            whole = -s64_t'(u64_t'(-total) >> FRAC);
        end
        else
        begin
            whole = total >>> FRAC;
        end
        carry = total - whole * s64_t'(ONE_Q);
        if (whole > s64_t'(DELTA_MAX))
        begin
            return DELTA_MAX;
        end
        if (whole < s64_t'(DELTA_MIN))
        begin
            return DELTA_MIN;
        end
        return DELTA_W'(whole);
    endfunction

    function automatic delta_t next_pointer_delta(input sample_t s);
        delta_t d;
        d.delta_x = scale_axis(s.rate_x, gain_x_cfg, carry_x);
        d.delta_y = scale_axis(s.rate_y, gain_y_cfg, carry_y);
        return d;
    endfunction

    function automatic logic signed [RATE_W-1:0] random_rate();
        logic signed [RATE_W-1:0] r;
        r = RATE_W'($urandom);
        return r >>> $urandom_range(0, RATE_W - 1);
    endfunction

    function automatic logic signed [GAIN_W-1:0] random_gain();
        logic signed [GAIN_W-1:0] g;
        g = $urandom;
        return g >>> $urandom_range(0, GAIN_W - 1);
    endfunction

    task automatic send_sample(input sample_t s, input logic typed, input delta_t want);
        delta_t predicted;
        sample_valid <= 1'b1;
        sample       <= s;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ready);
        predicted = next_pointer_delta(s);
        if (s.emit)
        begin
            pending_deltas.push_back(typed ? want : predicted);
        end
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // samples without emit leave nothing to wait on, so allow the latency too
    task automatic settle_block();
        sample_valid <= 1'b0;
        while (pending_deltas.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GAIN_X: gain_x_cfg = data;
            REG_GAIN_Y: gain_y_cfg = data;
            REG_MULT:   mult_cfg   = data[MULT_W-1:0];
            default:    ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && delta_valid && delta_ready)
        begin
            if (pending_deltas.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected delta item: x=%0d y=%0d",
                             delta.delta_x, delta.delta_y);
                end
            end
            else
            begin
                oldest_delta = pending_deltas.pop_front();
                if (delta.delta_x !== oldest_delta.delta_x
                    || delta.delta_y !== oldest_delta.delta_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("delta mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 oldest_delta.delta_x, oldest_delta.delta_y,
                                 delta.delta_x, delta.delta_y);
                    end
                end
            end
        end
    end

    // delta side back-pressure
    initial
    begin
        delta_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                delta_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                delta_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                delta_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                delta_ready <= 1'b1;
            end
            else
            begin
                delta_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        sample_t                  item;
        logic [MULT_W-1:0]        m;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct   = 25;
        stall_pct = 25;
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (directed[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(directed[i].index, directed[i].data);
            end
            else
            begin
                send_sample(directed[i].item, directed[i].typed, directed[i].want);
                maybe_gap();
            end
        end

        for (int ph = 0; ph < NUM_RUNS; ph++)
        begin
            settle_block();
            if (ph == 2)
            begin
                write_reg(REG_GAIN_X, 32'h80000000);
                write_reg(REG_GAIN_Y, 32'h7fffffff);
                write_reg(REG_MULT, 32'h00ffffff);
            end
            else
            begin
                write_reg(REG_GAIN_X, random_gain());
                write_reg(REG_GAIN_Y, random_gain());
                m = MULT_W'($urandom);
                m = m >> $urandom_range(0, MULT_W - 1);
                write_reg(REG_MULT, (ph == 4) ? {8'($urandom), MULT_RESET}
                                              : {8'($urandom), m});
            end
            if (ph == 3)
            begin
                write_reg(REG_SPARE, $urandom);
            end
            case (ph)
                0:       begin gap_pct = 30; stall_pct = 30; end
                1:       begin gap_pct = 0;  stall_pct = 10; hold_off_req = 1'b1; end
                2:       begin gap_pct = 50; stall_pct = 0;  end
                3:       begin gap_pct = 0;  stall_pct = 50; end
                4:       begin gap_pct = 20; stall_pct = 20; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                item.rate_x = random_rate();
                item.rate_y = random_rate();
                item.emit   = ($urandom_range(0, 9) < 8);
                send_sample(item, 1'b0, '0);
                maybe_gap();
            end
        end

        settle_block();
        if (mismatches == 0 && pending_deltas.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
